// ===== design/assert_macros.svh =====
// Shared assertion macros; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== design/ntcb_pkg.sv =====
`default_nettype none

package ntcb_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int OHMS_W     = 20;
    localparam int BETA_W     = 14;
    localparam int TREF_W     = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SERIES = 2'd0,
        REG_REF    = 2'd1,
        REG_BETA   = 2'd2,
        REG_TREF   = 2'd3
    } cfg_reg_t;

    // log2 lanes
    localparam int LOG_IN_W   = 20;
    localparam int LOG_INT_W  = 5;
    localparam int FRAC_BITS  = 20;
    localparam int LOG_W      = LOG_INT_W + FRAC_BITS;
    localparam int MANT_W     = 31;
    localparam int LOG_STAGES = FRAC_BITS;

    // datapath widths
    localparam int D_W     = 27;
    localparam int LN2_W   = 21;
    localparam int PROD_W  = 48;
    localparam int LND_W   = PROD_W - FRAC_BITS;
    localparam int TK_W    = 16;
    localparam int LT_W    = LND_W + TK_W + 1;
    localparam int PB_W    = 21;
    localparam int NUMC_W  = 37;
    localparam int DEN_W   = 46;
    localparam int DIV_D_W = 45;
    localparam int NUM_W   = 58;
    localparam int QUOT_W  = 18;
    localparam int TEMP_W  = 19;

    localparam logic signed [LN2_W-1:0]  LN2_Q20      = 21'sd726817;
    localparam logic signed [TK_W:0]     KELVIN_CENTI = 17'sd27315;
    localparam logic [PB_W-1:0]          CENTI_SCALE  = 21'd100;
    localparam logic [QUOT_W-1:0]        QUOT_SAT     = 18'd227315;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 19'sd200000;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN     = -19'sd27315;

    // control bits that travel with each item
    typedef struct packed {
        logic valid;
        logic bad;
        logic sat;
    } ntcb_tag_t;

endpackage

`default_nettype wire

// ===== design/ntcb_log2.sv =====
`default_nettype none

module ntcb_log2 (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ntcb_pkg::LOG_IN_W-1:0] x,
    output logic [ntcb_pkg::LOG_W-1:0]    lg
);
    import ntcb_pkg::*;

    logic [LOG_INT_W-1:0] lead;
    logic [LOG_INT_W-1:0] shamt;
    logic [MANT_W-1:0]    mant;

    logic [LOG_INT_W-1:0] n_reg [0:LOG_STAGES];
    logic [MANT_W-1:0]    m_reg [0:LOG_STAGES];
    logic [FRAC_BITS-1:0] f_reg [0:LOG_STAGES];

    logic [2*MANT_W-1:0]  sq     [1:LOG_STAGES];
    logic [MANT_W:0]      sq_hi  [1:LOG_STAGES];
    logic [MANT_W-1:0]    m_next [1:LOG_STAGES];
    logic                 b_next [1:LOG_STAGES];

    // leading one and normalize to Q1.30
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < LOG_IN_W; i++)
        begin
            if (x[i])
            begin
                lead = LOG_INT_W'(i);
            end
        end
        shamt = LOG_INT_W'(MANT_W - 1) - lead;
        mant  = MANT_W'(x) << shamt;
    end

    // one squaring per stage gives one fraction bit
    always_comb
    begin
        for (int j = 1; j <= LOG_STAGES; j++)
        begin
            sq[j]     = (2*MANT_W)'(m_reg[j-1]) * (2*MANT_W)'(m_reg[j-1]);
            sq_hi[j]  = sq[j][2*MANT_W-1:MANT_W-1];
            b_next[j] = sq_hi[j][MANT_W];
            m_next[j] = b_next[j] ? sq_hi[j][MANT_W:1] : sq_hi[j][MANT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= lead;
            m_reg[0] <= mant;
            f_reg[0] <= '0;
            for (int j = 1; j <= LOG_STAGES; j++)
            begin
                n_reg[j] <= n_reg[j-1];
                m_reg[j] <= m_next[j];
                f_reg[j] <= {f_reg[j-1][FRAC_BITS-2:0], b_next[j]};
            end
        end
    end

    assign lg = {n_reg[LOG_STAGES], f_reg[LOG_STAGES]};

endmodule

`default_nettype wire

// ===== design/ntcb_div.sv =====
`default_nettype none
`include "assert_macros.svh"

module ntcb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  ntcb_pkg::ntcb_tag_t           in_tag,
    input  logic [ntcb_pkg::NUM_W-1:0]    num,
    input  logic [ntcb_pkg::DIV_D_W-1:0]  den,
    output ntcb_pkg::ntcb_tag_t           out_tag,
    output logic [ntcb_pkg::QUOT_W-1:0]   quot
);
    import ntcb_pkg::*;

    localparam int WIDE_W = DIV_D_W + QUOT_W;

    logic      ovf;
    ntcb_tag_t tag0;

    ntcb_tag_t            tag_reg [0:QUOT_W];
    logic [NUM_W-1:0]     rem_reg [0:QUOT_W];
    logic [DIV_D_W-1:0]   den_reg [0:QUOT_W];
    logic [QUOT_W-1:0]    q_reg   [0:QUOT_W];

    logic [WIDE_W-1:0]    trial  [1:QUOT_W];
    logic                 take   [1:QUOT_W];
    logic [NUM_W-1:0]     rem_nx [1:QUOT_W];
    logic [QUOT_W-1:0]    q_nx   [1:QUOT_W];

    // quotient beyond the bit budget saturates
    always_comb
    begin
        ovf      = WIDE_W'(num) >= (WIDE_W'(den) << QUOT_W);
        tag0     = in_tag;
        tag0.sat = in_tag.sat | ovf;
    end

    // restoring division, one quotient bit per stage
    always_comb
    begin
        for (int k = 1; k <= QUOT_W; k++)
        begin
            trial[k]  = WIDE_W'(den_reg[k-1]) << (QUOT_W - k);
            take[k]   = WIDE_W'(rem_reg[k-1]) >= trial[k];
            rem_nx[k] = take[k] ? (rem_reg[k-1] - trial[k][NUM_W-1:0]) : rem_reg[k-1];
            q_nx[k]   = take[k] ? (q_reg[k-1] | (QUOT_W'(1) << (QUOT_W - k)))
                                : q_reg[k-1];
        end
    end

    // control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QUOT_W; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= tag0;
            for (int k = 1; k <= QUOT_W; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            for (int k = 1; k <= QUOT_W; k++)
            begin
                rem_reg[k] <= rem_nx[k];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_nx[k];
            end
        end
    end

    assign out_tag = tag_reg[QUOT_W];
    assign quot    = q_reg[QUOT_W];

    `ASSERT_IMPL(a_div_rem_below_den, tag_reg[QUOT_W].valid && !tag_reg[QUOT_W].sat, rem_reg[QUOT_W] < NUM_W'(den_reg[QUOT_W]), "divider remainder not below divisor")
    `ASSERT_IMPL(a_div_first_rem, tag_reg[0].valid && !tag_reg[0].sat, WIDE_W'(rem_reg[0]) < (WIDE_W'(den_reg[0]) << QUOT_W), "divider entered with quotient overflow")

endmodule

`default_nettype wire

// ===== design/ntc_beta_temperature.sv =====
// NTC thermistor temperature, beta equation, fixed point.
// Pipeline from input transfer to result: 21 log2 stages, 6 arithmetic stages,
// 19 divider stages and 1 output register; all of them hold only while stalled.
// Throughput: one code per cycle while the output is not stalled; every stage is fully pipelined.
// Reset: asynchronous active-low; clears valid bits and loads register defaults.
`default_nettype none
`include "assert_macros.svh"

module ntc_beta_temperature #(
    parameter int ADC_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ntcb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ntcb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ADC_BITS-1:0]                adc_code,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ntcb_pkg::TEMP_W-1:0] temp_centi,
    output logic                               invalid
);
    import ntcb_pkg::*;

    // configuration registers
    logic [OHMS_W-1:0]        series_reg;
    logic [OHMS_W-1:0]        ref_reg;
    logic [BETA_W-1:0]        beta_reg;
    logic signed [TREF_W-1:0] tref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_reg <= 20'd4700;
            ref_reg    <= 20'd10000;
            beta_reg   <= 14'd3950;
            tref_reg   <= 15'sd2500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SERIES: series_reg <= cfg_data[OHMS_W-1:0];
                REG_REF:    ref_reg    <= cfg_data[OHMS_W-1:0];
                REG_BETA:   beta_reg   <= cfg_data[BETA_W-1:0];
                REG_TREF:   tref_reg   <= $signed(cfg_data[TREF_W-1:0]);
            endcase
        end
    end

    // constants derived from config; user keeps it stable while items are in flight (unenforced)
    logic signed [TK_W:0] t0_sum;
    logic [TK_W-1:0]      t0_reg;
    logic [PB_W-1:0]      pb_reg;
    logic [NUMC_W-1:0]    numc_reg;

    assign t0_sum = (TK_W+1)'(tref_reg) + KELVIN_CENTI;

    always_ff @(posedge clk)
    begin
        t0_reg   <= t0_sum[TK_W-1:0];
        pb_reg   <= PB_W'(beta_reg) * CENTI_SCALE;
        numc_reg <= NUMC_W'(pb_reg) * NUMC_W'(t0_reg);
    end

    // global advance: everything moves unless the output is held
    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // entry
    logic [ADC_BITS:0]     fs_minus;
    logic [LOG_W-1:0]      lg_s, lg_c, lg_f, lg_r;
    ntcb_tag_t             tag_in;

    assign fs_minus = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, adc_code};

    always_comb
    begin
        tag_in.valid = in_valid;
        tag_in.bad   = (adc_code == '0) || (series_reg == '0) || (ref_reg == '0);
        tag_in.sat   = 1'b0;
    end

    ntcb_log2 u_log_series (.clk(clk), .en(en), .x(series_reg), .lg(lg_s));
    ntcb_log2 u_log_code   (.clk(clk), .en(en), .x(LOG_IN_W'(adc_code)), .lg(lg_c));
    ntcb_log2 u_log_rest   (.clk(clk), .en(en), .x(LOG_IN_W'(fs_minus)), .lg(lg_f));
    ntcb_log2 u_log_ref    (.clk(clk), .en(en), .x(ref_reg), .lg(lg_r));

    // tags alongside the log lanes, then through the arithmetic stages
    ntcb_tag_t tag_log_reg [0:LOG_STAGES];
    ntcb_tag_t tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg, tag_e_reg, tag_f_reg;
    ntcb_tag_t tag_f_next;

    // arithmetic stage registers
    logic signed [D_W-1:0]    d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [LND_W-1:0]  lnd_reg;
    logic signed [LT_W-1:0]   lt_reg;
    logic signed [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DIV_D_W-1:0]       divd_reg;

    logic signed [D_W-1:0]    d_next;
    logic signed [PROD_W-1:0] prod_next;
    logic [FRAC_BITS-1:0]     bias;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [LT_W-1:0]   lt_next;
    logic signed [DEN_W-1:0]  den_next;
    logic [DIV_D_W-1:0]       divd_next;
    logic [NUM_W-1:0]         num_next;

    always_comb
    begin
        // log difference, Q.20
        d_next    = $signed(D_W'(lg_s)) + $signed(D_W'(lg_c))
                  - $signed(D_W'(lg_f)) - $signed(D_W'(lg_r));
        // scale to natural log, truncate toward zero
        prod_next = d_reg * LN2_Q20;
        bias      = prod_reg[PROD_W-1] ? {FRAC_BITS{1'b1}} : '0;
        prod_adj  = prod_reg + $signed({{(PROD_W-FRAC_BITS){1'b0}}, bias});
        lt_next   = lnd_reg * $signed({1'b0, t0_reg});
        den_next  = $signed(DEN_W'({pb_reg, {FRAC_BITS{1'b0}}})) + DEN_W'(lt_reg);
        // denominator at or below zero means past the pole
        tag_f_next     = tag_e_reg;
        tag_f_next.sat = tag_e_reg.sat | den_reg[DEN_W-1] | (den_reg == '0);
        divd_next = den_reg[DIV_D_W-1:0];
        num_next  = NUM_W'({numc_reg, {FRAC_BITS{1'b0}}}) + NUM_W'(divd_next >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LOG_STAGES; i++)
            begin
                tag_log_reg[i] <= '0;
            end
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
            tag_e_reg <= '0;
            tag_f_reg <= '0;
        end
        else if (en)
        begin
            tag_log_reg[0] <= tag_in;
            for (int i = 1; i <= LOG_STAGES; i++)
            begin
                tag_log_reg[i] <= tag_log_reg[i-1];
            end
            tag_a_reg <= tag_log_reg[LOG_STAGES];
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
            tag_e_reg <= tag_d_reg;
            tag_f_reg <= tag_f_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= d_next;
            prod_reg <= prod_next;
            lnd_reg  <= $signed(prod_adj[PROD_W-1:FRAC_BITS]);
            lt_reg   <= lt_next;
            den_reg  <= den_next;
            num_reg  <= num_next;
            divd_reg <= divd_next;
        end
    end

    // rounded division to centikelvin
    ntcb_tag_t         tag_q;
    logic [QUOT_W-1:0] quot;

    ntcb_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_tag  (tag_f_reg),
        .num     (num_reg),
        .den     (divd_reg),
        .out_tag (tag_q),
        .quot    (quot)
    );

    // output register: convert to Celsius and saturate; invalid items give the floor value
    logic signed [TEMP_W-1:0] temp_next;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     invalid_reg;

    always_comb
    begin
        priority if (tag_q.bad)
        begin
            temp_next = TEMP_MIN;
        end
        else if (tag_q.sat || (quot > QUOT_SAT))
        begin
            temp_next = TEMP_MAX;
        end
        else
        begin
            temp_next = $signed({1'b0, quot}) - TEMP_W'(KELVIN_CENTI);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= tag_q.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg    <= temp_next;
            invalid_reg <= tag_q.bad;
        end
    end

    assign out_valid  = out_valid_reg;
    assign temp_centi = temp_reg;
    assign invalid    = invalid_reg;

    `ASSERT_IMPL(a_invalid_floor, out_valid && invalid, temp_centi == TEMP_MIN, "invalid result without floor temperature")
    `ASSERT_NEVER(a_temp_range, out_valid && !invalid && ((temp_centi > TEMP_MAX) || (temp_centi < TEMP_MIN)), "temperature outside saturation range")

endmodule

`default_nettype wire

// ===== verif/ntc_beta_temperature_checker.sv =====
`timescale 1ns / 100ps

module ntc_beta_temperature_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ntcb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ntcb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [11:0]                        adc_code,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [ntcb_pkg::TEMP_W-1:0] temp_centi,
    input  logic                               invalid,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 result_count
);
    import ntcb_pkg::*;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     bad;
    } reading_t;

    // shadow copy of the register file
    logic [OHMS_W-1:0]        series_r;
    logic [OHMS_W-1:0]        refres_r;
    logic [BETA_W-1:0]        beta_r;
    logic signed [TREF_W-1:0] tref_r;

    reading_t expected_readings[$];

    // log2 of x in Q.20 by repeated squaring of the mantissa
    function automatic longint log2_fix(longint unsigned x);
        int             msb;
        longint unsigned m;
        longint         frac;
        msb = 0;
        frac = 0;
        for (int i = 0; i < 32; i++)
            if (x[i]) msb = i;
        m = x << (30 - msb);
        for (int i = 0; i < 20; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(msb) << 20) + frac;
    endfunction

    function automatic reading_t convert_code(logic [11:0] code);
        reading_t r;
        longint   d, lnd, t0, base, num, den, tck, t;
        if (code == 0 || series_r == 0 || refres_r == 0)
        begin
            r.temp = TEMP_MIN;
            r.bad = 1'b1;
            return r;
        end
        d = log2_fix(series_r) + log2_fix(code) - log2_fix(4096 - code) - log2_fix(refres_r);
        lnd = (d * 726817) / (64'sd1 <<< 20);
        t0 = longint'(tref_r) + 27315;
        base = 100 * longint'(beta_r) * (64'sd1 <<< 20);
        num = t0 * base;
        den = base + lnd * t0;
        if (den <= 0)
            t = 200000;
        else
        begin
            tck = (num + den / 2) / den;
            t = tck - 27315;
            if (t > 200000) t = 200000;
            if (t < -27315) t = -27315;
        end
        r.temp = TEMP_W'(t);
        r.bad = 1'b0;
        return r;
    endfunction

    assign pending = expected_readings.size();

    // register writes, input transfers and result transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_r <= 20'd4700;
            refres_r <= 20'd10000;
            beta_r <= 14'd3950;
            tref_r <= 15'sd2500;
            fail_count <= 0;
            result_count <= 0;
            expected_readings.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SERIES: series_r <= cfg_data[OHMS_W-1:0];
                    REG_REF:    refres_r <= cfg_data[OHMS_W-1:0];
                    REG_BETA:   beta_r <= cfg_data[BETA_W-1:0];
                    REG_TREF:   tref_r <= cfg_data[TREF_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_readings.push_back(convert_code(adc_code));
            if (out_valid && !out_stall)
            begin
                result_count <= result_count + 1;
                if (expected_readings.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: temp %0d invalid %0b",
                            temp_centi, invalid);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    reading_t e;
                    e = expected_readings.pop_front();
                    if (e.temp !== temp_centi || e.bad !== invalid)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected temp %0d invalid %0b, got %0d %0b",
                                e.temp, e.bad, temp_centi, invalid);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/ntc_beta_temperature_test.sv =====
`timescale 1ns / 100ps

module ntc_beta_temperature_test;
    import ntcb_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [11:0]              adc_code;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [TEMP_W-1:0] temp_centi;
    logic                     invalid;
    int                       fail_count;
    int                       pending;
    int                       result_count;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  cycle_count = 0;
    int  code_count;

    ntc_beta_temperature uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .adc_code(adc_code),
        .out_valid(out_valid), .out_stall(out_stall),
        .temp_centi(temp_centi), .invalid(invalid)
    );

    ntc_beta_temperature_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .adc_code(adc_code),
        .out_valid(out_valid), .out_stall(out_stall),
        .temp_centi(temp_centi), .invalid(invalid),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver stall, random or held off for a long stretch
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("timeout");
            $display("[ntc_beta_temperature] ERROR");
            $finish;
        end
    end

    // one code transfer, with optional idle gap first
    task automatic send_code(logic [11:0] code);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_code <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        code_count++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_regs(int ser, int rres, int beta, int tref);
        write_reg(REG_SERIES, CFG_DATA_W'(ser));
        write_reg(REG_REF, CFG_DATA_W'(rres));
        write_reg(REG_BETA, CFG_DATA_W'(beta));
        write_reg(REG_TREF, 20'(tref) & 20'h7FFF);
        @(posedge clk);
    endtask

    // random codes biased toward the ends of the scale
    task automatic random_codes(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: send_code(12'($urandom_range(3)));
                1: send_code(12'(4095 - $urandom_range(3)));
                default: send_code(12'($urandom));
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        adc_code = '0;
        hold_off = 1'b0;
        code_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, edges of the code range
        send_code(12'd0);
        send_code(12'd1);
        send_code(12'd2048);
        send_code(12'd4094);
        send_code(12'd4095);
        send_code(12'hAAA);
        send_code(12'h555);
        drain();
        // zero resistors give invalid
        load_regs(0, 10000, 3950, 2500);
        send_code(12'd1000);
        drain();
        load_regs(4700, 0, 3950, 2500);
        send_code(12'd1000);
        drain();
        // zero beta, extreme registers, pole crossing and saturation
        load_regs(1000000, 1, 0, -4000);
        send_code(12'd1);
        send_code(12'd2000);
        send_code(12'd4095);
        drain();
        load_regs(1, 1000000, 1, 15000);
        send_code(12'd1);
        send_code(12'd4095);
        send_code(12'd3000);
        drain();
        load_regs(1000000, 1000000, 10000, 15000);
        send_code(12'd1);
        send_code(12'd4095);
        drain();

        // random phases with varying idling and settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 55; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 55; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 0)
                load_regs(4700, 10000, 3950, 2500);
            else
                load_regs($urandom_range(1, 1000000), $urandom_range(1, 1000000),
                    $urandom_range(1, 10000), $urandom_range(0, 19000) - 4000);
            if (ph == 2)
            begin
                // long hold-off while codes keep coming
                fork
                    begin
                        hold_off <= 1'b1;
                        for (int c = 0; c < 300; c++)
                            @(posedge clk);
                        hold_off <= 1'b0;
                    end
                    random_codes(80);
                join
            end
            else
                random_codes(40);
            drain();
        end

        $display("%0d codes sent, %0d results checked over reset, extreme and random settings",
            code_count, result_count);
        if (fail_count == 0)
            $display("[ntc_beta_temperature] OK");
        else
            $display("[ntc_beta_temperature] ERROR");
        $finish;
    end

endmodule
